/* hw/rtl/vrcm_pkg.sv */
// Shared types, codes and constants of the bank-switching cartridge mapper.
// Used by the CHR bank store, the remainder unit, the core and its checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vrcm_pkg;

  // Number of 1K CHR bank slots and the width of a slot index.
  localparam int CHR_SLOTS = 8;
  localparam int CHR_IDX_W = $clog2(CHR_SLOTS);

  // Field widths.
  localparam int PRG_CNT_W = 9;
  localparam int CHR_CNT_W = 10;
  localparam int CHR_BANK_W = 9;
  localparam int PRG_BANK_W = 8;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W = 2;
  localparam int OFFSET_W = 19;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_PRESENT = 2'd2;

  // Configuration reset values.
  localparam logic [PRG_CNT_W-1:0] PRG_COUNT_RESET = 9'd32;
  localparam logic [CHR_CNT_W-1:0] CHR_COUNT_RESET = 10'd256;
  localparam logic PRG_RAM_RESET = 1'b1;
  localparam logic [PRG_BANK_W-1:0] PRG_BANK_RESET = 8'd30;

  // Target region codes.
  localparam logic [2:0] TGT_NONE = 3'd0;
  localparam logic [2:0] TGT_CHR = 3'd1;
  localparam logic [2:0] TGT_NT = 3'd2;
  localparam logic [2:0] TGT_RAM = 3'd3;
  localparam logic [2:0] TGT_ROM = 3'd4;

  // Register select groups, address bits 15:12 of a bank register write.
  localparam logic [3:0] SEL_PRG_SW = 4'h8;
  localparam logic [3:0] SEL_MODE = 4'h9;
  localparam logic [3:0] SEL_PRG_MID = 4'hA;
  localparam logic [3:0] SEL_CHR_BASE = 4'hB;
  localparam logic [3:0] SEL_IRQ = 4'hF;

  // Kind of bank register write.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PRG_SW,
    OP_PRG_MID,
    OP_MIRROR,
    OP_SWAP,
    OP_CHR
  } wr_op_t;

  // Control state of the core.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DIV,
    ST_STORE,
    ST_FIN
  } state_t;

  // Request to the remainder unit.
  typedef struct packed {
    logic                  start;
    logic [CHR_BANK_W-1:0] dividend;
    logic [CHR_CNT_W-1:0]  divisor;
  } div_req_t;

  // Write request to the CHR bank store.
  typedef struct packed {
    logic                  en;
    logic [CHR_IDX_W-1:0]  addr;
    logic [CHR_BANK_W-1:0] data;
  } chr_wr_t;

  // One result; target sits in the lowest bits.
  typedef struct packed {
    logic [1:0]          mirror_mode;
    logic [7:0]          data_out;
    logic                mem_write;
    logic [OFFSET_W-1:0] phys_offset;
    logic [2:0]          target;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/vrcm_chr_store.sv */
// CHR bank store: eight 9-bit bank numbers in a synchronous memory.
// Valid bits make an unwritten entry read as its own index. Uses vrcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vrcm_chr_store (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             rd_en,
  input  wire logic [vrcm_pkg::CHR_IDX_W-1:0]   rd_addr,
  input  wire vrcm_pkg::chr_wr_t                wr,
  output logic      [vrcm_pkg::CHR_BANK_W-1:0]  rd_data
);

  logic [vrcm_pkg::CHR_BANK_W-1:0] mem [vrcm_pkg::CHR_SLOTS];
  logic [vrcm_pkg::CHR_SLOTS-1:0]  valid;
  logic [vrcm_pkg::CHR_BANK_W-1:0] mem_q;
  logic                            valid_q;
  logic [vrcm_pkg::CHR_IDX_W-1:0]  addr_q;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      addr_q <= rd_addr;
    end
  end

  // Valid bits: reset marks every entry as holding its reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        valid_q <= valid[rd_addr];
      end
    end
  end

  // An entry never written reads as its own index.
  assign rd_data = valid_q ? mem_q
                           : {{(vrcm_pkg::CHR_BANK_W-vrcm_pkg::CHR_IDX_W){1'b0}}, addr_q};

endmodule

`default_nettype wire

/* hw/rtl/vrcm_rem_unit.sv */
// Bit-serial remainder unit: 9-bit dividend modulo a 10-bit count.
// One restoring step per cycle; a zero count passes the dividend. Uses vrcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vrcm_rem_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire vrcm_pkg::div_req_t               req,
  output logic                                  done,
  output logic      [vrcm_pkg::CHR_BANK_W-1:0]  rem
);

  localparam int DW = vrcm_pkg::CHR_BANK_W;
  localparam int VW = vrcm_pkg::CHR_CNT_W;
  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] quo;
  logic [VW-1:0] div;
  logic [VW-1:0] part;
  logic [VW:0]   trial;
  logic [VW:0]   diff;

  // One restoring step: shift in the next dividend bit and subtract if it fits.
  assign trial = {part, quo[DW-1]};
  assign diff = trial - {1'b0, div};

  // Control: busy flag, step counter and the done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (req.divisor == '0) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt <= CW'(DW);
        end
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and dividend shift register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      div <= req.divisor;
      quo <= req.dividend;
      if (req.divisor == '0) begin
        part <= {{(VW-DW){1'b0}}, req.dividend};
      end else begin
        part <= '0;
      end
    end else if (busy) begin
      quo <= {quo[DW-2:0], 1'b0};
      if (!diff[VW]) begin
        part <= diff[VW-1:0];
      end else begin
        part <= trial[VW-1:0];
      end
    end
  end

  // The remainder never exceeds the dividend, so it fits the dividend width.
  assign rem = part[DW-1:0];

endmodule

`default_nettype wire

/* hw/rtl/vrc_bank_mapper_core.sv */
// Top level of the bank-switching cartridge mapper.
// Depends on vrcm_pkg, vrcm_chr_store and vrcm_rem_unit.
//
//   Channel  Dir  Handshake          Payload
//   s_*      in   s_tvalid/s_tready  s_tuser kind, s_tdata bus_address, data_in
//   m_*      out  m_tvalid/m_tready  m_tdata target .. mirror_mode
//   cfg_*    in   cfg_we             cfg_index, cfg_data (no read-back)
//
// A bus access or a mode write passes through the lookup and finish states
// before its result reaches the output register. A PRG or CHR bank write also
// waits on the bit-serial remainder unit (one step per dividend bit; none with
// a zero bank count) and then passes the store state. One request is in work
// at a time; a new one is accepted while the previous result waits on m_tready.
// Reset is synchronous; it clears the control state and returns the bank
// registers to their reset values.
`timescale 1ns / 1ps
`default_nettype none

module vrc_bank_mapper_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Input requests.
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [23:0]                         s_tdata,  // bus_address, data_in
  input  wire logic                                s_tuser,  // kind
  // Results.
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [39:0]                         m_tdata,  // target, phys_offset,
                                                             // mem_write, data_out,
                                                             // mirror_mode, zero fill
  // Configuration writes.
  input  wire logic                                cfg_we,
  input  wire logic [vrcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [vrcm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int RES_W = $bits(vrcm_pkg::res_t);

  // Configuration registers.
  logic [vrcm_pkg::PRG_CNT_W-1:0] prg_bank_count;
  logic [vrcm_pkg::CHR_CNT_W-1:0] chr_bank_count;
  logic                           prg_ram_present;

  // Bank state held in flip-flops.
  logic [vrcm_pkg::PRG_BANK_W-1:0] prg_bank_switchable;
  logic [vrcm_pkg::PRG_BANK_W-1:0] prg_bank_middle;
  logic                            prg_swap;
  logic [1:0]                      mirroring;
  logic [1:0]                      mirroring_next;

  // Request being worked on.
  logic        kind_q;
  logic [15:0] addr_q;
  logic [7:0]  data_q;

  vrcm_pkg::state_t state;
  vrcm_pkg::state_t state_next;

  logic                               accept;
  logic                               out_load;
  logic                               need_div;
  logic [vrcm_pkg::CHR_IDX_W-1:0]     rd_addr;
  logic [vrcm_pkg::CHR_BANK_W-1:0]    chr_entry;
  logic [vrcm_pkg::CHR_BANK_W-1:0]    chr_new;
  logic [vrcm_pkg::CHR_IDX_W-1:0]     chr_idx;
  logic [1:0]                         low;
  logic [3:0]                         chr_grp;
  vrcm_pkg::wr_op_t                   op;
  vrcm_pkg::div_req_t                 div_req;
  vrcm_pkg::chr_wr_t                  chr_wr;
  logic                               div_done;
  logic [vrcm_pkg::CHR_BANK_W-1:0]    div_rem;
  logic [vrcm_pkg::PRG_CNT_W-1:0]     second_last;
  logic [vrcm_pkg::PRG_CNT_W-1:0]     last;
  logic [vrcm_pkg::PRG_CNT_W-1:0]     rom_bank;
  vrcm_pkg::res_t                     look_res;
  vrcm_pkg::res_t                     store_res;
  vrcm_pkg::res_t                     pend_res;
  vrcm_pkg::res_t                     out_res;

  assign accept = s_tvalid && s_tready;

  // Register selects: A0|A2 and A1|A3.
  assign low = {addr_q[1] | addr_q[3], addr_q[0] | addr_q[2]};
  assign chr_grp = addr_q[15:12] - vrcm_pkg::SEL_CHR_BASE;
  assign chr_idx = {chr_grp[1:0], low[1]};

  // Decode a bank register write.
  always_comb begin
    op = vrcm_pkg::OP_NONE;
    if (kind_q && addr_q[15]) begin
      case (addr_q[15:12])
        vrcm_pkg::SEL_PRG_SW:  op = vrcm_pkg::OP_PRG_SW;
        vrcm_pkg::SEL_MODE:    op = low[1] ? vrcm_pkg::OP_SWAP : vrcm_pkg::OP_MIRROR;
        vrcm_pkg::SEL_PRG_MID: op = vrcm_pkg::OP_PRG_MID;
        vrcm_pkg::SEL_IRQ:     op = vrcm_pkg::OP_NONE;
        default:               op = vrcm_pkg::OP_CHR;
      endcase
    end
  end

  // Store read address, taken straight from the incoming request.
  always_comb begin
    logic [3:0] grp;
    logic       hi;
    grp = s_tdata[15:12] - vrcm_pkg::SEL_CHR_BASE;
    hi = s_tdata[1] | s_tdata[3];
    if (s_tdata[15]) begin
      rd_addr = {grp[1:0], hi};
    end else begin
      rd_addr = s_tdata[12:10];
    end
  end

  // New CHR bank value from one nibble write.
  assign chr_new = low[0] ? {data_q[4:0], chr_entry[3:0]}
                          : {chr_entry[8:4], data_q[3:0]};

  assign need_div = (op == vrcm_pkg::OP_PRG_SW) || (op == vrcm_pkg::OP_PRG_MID) ||
                    (op == vrcm_pkg::OP_CHR);

  // Fixed PRG banks wrap in 9 bits.
  assign second_last = prg_bank_count - 9'd2;
  assign last = prg_bank_count - 9'd1;

  always_comb begin
    case (addr_q[14:13])
      2'd0:    rom_bank = prg_swap ? second_last : {1'b0, prg_bank_switchable};
      2'd1:    rom_bank = {1'b0, prg_bank_middle};
      2'd2:    rom_bank = prg_swap ? {1'b0, prg_bank_switchable} : second_last;
      default: rom_bank = last;
    endcase
  end

  // Mode register writes take effect at once.
  always_comb begin
    mirroring_next = mirroring;
    if (op == vrcm_pkg::OP_MIRROR) begin
      mirroring_next = data_q[1:0] ^ 2'b10;
    end
  end

  // Result of a bus access or a mode write, formed in the lookup cycle.
  always_comb begin
    look_res = '0;
    look_res.mirror_mode = mirroring_next;
    case (addr_q[15:13])
      3'd0: begin
        look_res.target = vrcm_pkg::TGT_CHR;
        look_res.phys_offset = {chr_entry, addr_q[9:0]};
        look_res.mem_write = kind_q;
      end
      3'd1: begin
        look_res.target = vrcm_pkg::TGT_NT;
        look_res.phys_offset = {7'd0, addr_q[11:0]};
        look_res.mem_write = kind_q;
      end
      3'd2: begin
        look_res.target = vrcm_pkg::TGT_NONE;
      end
      3'd3: begin
        if (prg_ram_present) begin
          look_res.target = vrcm_pkg::TGT_RAM;
          look_res.phys_offset = {6'd0, addr_q[12:0]};
          look_res.mem_write = kind_q;
        end
      end
      default: begin
        if (!kind_q) begin
          look_res.target = vrcm_pkg::TGT_ROM;
          look_res.phys_offset = {rom_bank[5:0], addr_q[12:0]};
        end
      end
    endcase
    if (look_res.mem_write) begin
      look_res.data_out = data_q;
    end
  end

  // Result of a bank number write: no target, current mirroring.
  always_comb begin
    store_res = '0;
    store_res.mirror_mode = mirroring;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      vrcm_pkg::ST_IDLE:  if (accept) state_next = vrcm_pkg::ST_LOOK;
      vrcm_pkg::ST_LOOK:  state_next = need_div ? vrcm_pkg::ST_DIV : vrcm_pkg::ST_FIN;
      vrcm_pkg::ST_DIV:   if (div_done) state_next = vrcm_pkg::ST_STORE;
      vrcm_pkg::ST_STORE: state_next = vrcm_pkg::ST_FIN;
      vrcm_pkg::ST_FIN:   if (out_load) state_next = vrcm_pkg::ST_IDLE;
      default:            state_next = vrcm_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    s_tready = (state == vrcm_pkg::ST_IDLE);
    out_load = (state == vrcm_pkg::ST_FIN) && (!m_tvalid || m_tready);
    div_req.start = (state == vrcm_pkg::ST_LOOK) && need_div;
    div_req.dividend = (op == vrcm_pkg::OP_CHR) ? chr_new : {4'd0, data_q[4:0]};
    div_req.divisor = (op == vrcm_pkg::OP_CHR) ? chr_bank_count
                                               : {1'b0, prg_bank_count};
    chr_wr.en = (state == vrcm_pkg::ST_STORE) && (op == vrcm_pkg::OP_CHR);
    chr_wr.addr = chr_idx;
    chr_wr.data = div_rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vrcm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= vrcm_pkg::PRG_COUNT_RESET;
      chr_bank_count <= vrcm_pkg::CHR_COUNT_RESET;
      prg_ram_present <= vrcm_pkg::PRG_RAM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        vrcm_pkg::CFG_PRG_COUNT:   prg_bank_count <= cfg_data[vrcm_pkg::PRG_CNT_W-1:0];
        vrcm_pkg::CFG_CHR_COUNT:   chr_bank_count <= cfg_data;
        vrcm_pkg::CFG_RAM_PRESENT: prg_ram_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Bank and mode registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_switchable <= vrcm_pkg::PRG_BANK_RESET;
      prg_bank_middle <= vrcm_pkg::PRG_BANK_RESET;
      prg_swap <= 1'b0;
      mirroring <= 2'd0;
    end else begin
      if (state == vrcm_pkg::ST_LOOK) begin
        mirroring <= mirroring_next;
        if (op == vrcm_pkg::OP_SWAP) begin
          prg_swap <= data_q[1];
        end
      end
      if (state == vrcm_pkg::ST_STORE) begin
        if (op == vrcm_pkg::OP_PRG_SW) begin
          prg_bank_switchable <= div_rem[vrcm_pkg::PRG_BANK_W-1:0];
        end
        if (op == vrcm_pkg::OP_PRG_MID) begin
          prg_bank_middle <= div_rem[vrcm_pkg::PRG_BANK_W-1:0];
        end
      end
    end
  end

  // Request capture and the pending result.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= s_tuser;
      addr_q <= s_tdata[15:0];
      data_q <= s_tdata[23:16];
    end
    if (state == vrcm_pkg::ST_LOOK) begin
      pend_res <= look_res;
    end else if (state == vrcm_pkg::ST_STORE) begin
      pend_res <= store_res;
    end
    if (out_load) begin
      out_res <= pend_res;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {{(40-RES_W){1'b0}}, out_res};

  vrcm_chr_store u_chr_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .wr      (chr_wr),
    .rd_data (chr_entry)
  );

  vrcm_rem_unit u_rem_unit (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .rem  (div_rem)
  );

endmodule

`default_nettype wire

/* hw/rtl/vrcm_checker.sv */
// Port-level checks of the bank mapper core, attached by a bind statement.
// Depends on vrcm_pkg and vrc_bank_mapper_core.
`timescale 1ns / 1ps
`default_nettype none

module vrcm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  vrcm_pkg::res_t res;
  assign res = m_tdata[$bits(vrcm_pkg::res_t)-1:0];

  // No result is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // An access that hits nothing carries no offset and no store.
  a_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res.target == vrcm_pkg::TGT_NONE) |-> res.phys_offset == '0 && !res.mem_write)
    else $error("empty target with offset or store");

  // ROM is only read, and data is zero when nothing is stored.
  a_rom_read: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res.target == vrcm_pkg::TGT_ROM) |-> !res.mem_write)
    else $error("store to PRG ROM");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !res.mem_write |-> res.data_out == 8'd0)
    else $error("data out without a store");

endmodule

bind vrc_bank_mapper_core vrcm_checker u_vrcm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the bank-switching cartridge mapper core.
// Holds its own bank-register model and drives random idle on both stream sides.
// Depends on vrcm_pkg and vrc_bank_mapper_core.
`timescale 1ns / 1ps

module testbench;
  import vrcm_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;  // bus_address, data_in
  logic s_tuser = 1'b0;       // kind
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;       // target, phys_offset, mem_write, data_out, mirror_mode
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Mapper state as the testbench expects it.
  logic [PRG_CNT_W-1:0] prg_count_cfg;
  logic [CHR_CNT_W-1:0] chr_count_cfg;
  logic ram_fitted;
  logic [PRG_BANK_W-1:0] bank_8000;
  logic [PRG_BANK_W-1:0] bank_a000;
  logic swap_on;
  logic [CHR_BANK_W-1:0] chr_map [CHR_SLOTS];
  logic [1:0] mirror_now;

  res_t due_q[$];
  res_t seen_res;
  res_t due_res;
  int mismatches = 0;
  int stall_cycles = 0;
  logic no_idle = 1'b0;

  vrc_bank_mapper_core DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // A zero bank count leaves the bank number unreduced.
  function automatic int unsigned bank_mod(input int unsigned v, input int unsigned cnt);
    return (cnt == 0) ? v : v % cnt;
  endfunction

  // Predict the result of one request and apply any bank register write.
  function automatic res_t map_access(input logic wr, input logic [15:0] a,
                                     input logic [7:0] d);
    res_t r;
    int unsigned off;
    int unsigned bank;
    int unsigned pc;
    int unsigned v;
    logic [1:0] low;
    logic [2:0] idx;
    r = '0;
    off = 0;
    pc = prg_count_cfg;
    low = a[3:2] | a[1:0];
    case (a[15:13])
      3'd0: begin
        r.target = TGT_CHR;
        off = chr_map[a[12:10]] * 1024 + a[9:0];
        r.mem_write = wr;
      end
      3'd1: begin
        r.target = TGT_NT;
        off = a[11:10] * 1024 + a[9:0];
        r.mem_write = wr;
      end
      3'd2: ;
      3'd3: begin
        if (ram_fitted) begin
          r.target = TGT_RAM;
          off = a[12:0];
          r.mem_write = wr;
        end
      end
      default: begin
        if (wr) begin
          // Bank register write; the result carries no target.
          case (a[15:12])
            SEL_PRG_SW: bank_8000 = PRG_BANK_W'(bank_mod(d[4:0], pc));
            SEL_MODE: begin
              if (low < 2) mirror_now = d[1:0] ^ 2'b10;
              else swap_on = d[1];
            end
            SEL_PRG_MID: bank_a000 = PRG_BANK_W'(bank_mod(d[4:0], pc));
            SEL_IRQ: ;
            default: begin
              idx = {2'(a[15:12] - SEL_CHR_BASE), low[1]};
              if (low[0]) v = (chr_map[idx] & 9'h00F) | (d[4:0] << 4);
              else v = (chr_map[idx] & 9'h1F0) | d[3:0];
              chr_map[idx] = CHR_BANK_W'(bank_mod(v, chr_count_cfg));
            end
          endcase
        end else begin
          // Fixed banks wrap in 9 bits when the count is below two.
          case (a[14:13])
            2'd0: bank = swap_on ? ((pc - 2) & 'h1FF) : bank_8000;
            2'd1: bank = bank_a000;
            2'd2: bank = swap_on ? bank_8000 : ((pc - 2) & 'h1FF);
            default: bank = (pc - 1) & 'h1FF;
          endcase
          r.target = TGT_ROM;
          off = bank * 'h2000 + a[12:0];
        end
      end
    endcase
    r.phys_offset = off[OFFSET_W-1:0];
    r.data_out = r.mem_write ? d : 8'h00;
    r.mirror_mode = mirror_now;
    return r;
  endfunction

  // Send one request; entered and left at a falling edge.
  task automatic send_access(input logic kind, input logic [15:0] addr, input logic [7:0] d);
    while (!no_idle && $urandom_range(99) < 37) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {d, addr};
    s_tuser <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    due_q.push_back(map_access(kind, addr, d));
    @(negedge clk);
  endtask

  // Wait until every expected result has come back and the core is quiet.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (due_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_PRG_COUNT: prg_count_cfg = val[PRG_CNT_W-1:0];
      CFG_CHR_COUNT: chr_count_cfg = val[CHR_CNT_W-1:0];
      CFG_RAM_PRESENT: ram_fitted = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_counts(input int unsigned prg, input int unsigned chr, input logic ram);
    wait_idle();
    write_reg(CFG_PRG_COUNT, CFG_DATA_W'(prg));
    write_reg(CFG_CHR_COUNT, CFG_DATA_W'(chr));
    write_reg(CFG_RAM_PRESENT, CFG_DATA_W'(ram));
  endtask

  // Random requests, weighted toward bank register writes and PRG/CHR reads.
  task automatic random_accesses(input int n);
    logic kind;
    logic [15:0] addr;
    logic [7:0] d;
    for (int i = 0; i < n; i++) begin
      d = 8'($urandom);
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          kind = 1'b1;
          addr = 16'h8000 | 16'($urandom);
        end
        4, 5: begin
          kind = 1'b0;
          addr = 16'h8000 | 16'($urandom);
        end
        6: begin
          kind = 1'b0;
          addr = 16'($urandom_range(16'h1FFF));
        end
        default: begin
          kind = 1'($urandom);
          addr = 16'($urandom);
        end
      endcase
      send_access(kind, addr, d);
    end
  endtask

  // Every region edge, every bank register kind and the ignored IRQ block.
  task automatic test_access_map();
    send_access(1'b0, 16'h0000, 8'h00);
    send_access(1'b1, 16'h1FFF, 8'hFF);
    send_access(1'b0, 16'h2000, 8'h5A);
    send_access(1'b1, 16'h3FFF, 8'hA5);
    send_access(1'b1, 16'h4000, 8'h77);
    send_access(1'b0, 16'h5FFF, 8'h00);
    send_access(1'b1, 16'h6000, 8'h3C);
    send_access(1'b0, 16'h7FFF, 8'h00);
    send_access(1'b0, 16'h8000, 8'h00);
    send_access(1'b0, 16'hA000, 8'h00);
    send_access(1'b0, 16'hC000, 8'h00);
    send_access(1'b0, 16'hFFFF, 8'h00);
    send_access(1'b1, 16'h9000, 8'h03);
    send_access(1'b1, 16'h9002, 8'h02);
    send_access(1'b0, 16'h8001, 8'h00);
    send_access(1'b0, 16'hDFFF, 8'h00);
    send_access(1'b1, 16'h8000, 8'hFF);
    send_access(1'b1, 16'hA00C, 8'h11);
    send_access(1'b0, 16'hC000, 8'h00);
    send_access(1'b1, 16'hB001, 8'hFF);
    send_access(1'b1, 16'hE00A, 8'h0F);
    send_access(1'b1, 16'hF003, 8'h12);
    send_access(1'b0, 16'h03FF, 8'h00);
    send_access(1'b0, 16'h1C00, 8'h00);
    send_access(1'b1, 16'h9001, 8'h00);
  endtask

  // Smallest, largest, zero and wrapping bank counts, RAM fitted and absent.
  task automatic test_count_extremes();
    set_counts(2, 8, 1'b0);
    random_accesses(110);
    set_counts(256, 512, 1'b1);
    random_accesses(110);
    set_counts(0, 0, 1'b1);
    random_accesses(110);
    set_counts(1, 1023, 1'b0);
    random_accesses(110);
    set_counts(511, 1, 1'b1);
    random_accesses(110);
  endtask

  // Arbitrary register values across the full data width.
  task automatic test_random_counts();
    for (int p = 0; p < 3; p++) begin
      set_counts($urandom_range(1023), $urandom_range(1023), 1'($urandom));
      random_accesses(100);
    end
  endtask

  // Back-to-back requests with both sides always ready.
  task automatic test_back_to_back();
    set_counts(32, 256, 1'b1);
    no_idle = 1'b1;
    random_accesses(100);
    wait_idle();
    no_idle = 1'b0;
  endtask

  // Result side ready pattern.
  always @(negedge clk) m_tready <= no_idle || ($urandom_range(99) >= 37);

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch: %s", $realtime, what);
  endtask

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_res = res_t'(m_tdata[$bits(res_t)-1:0]);
      if (due_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result tgt=%0d off=%h", seen_res.target,
                                seen_res.phys_offset));
      end else begin
        due_res = due_q.pop_front();
        if (seen_res.target !== due_res.target ||
            seen_res.phys_offset !== due_res.phys_offset ||
            seen_res.mem_write !== due_res.mem_write ||
            seen_res.data_out !== due_res.data_out ||
            seen_res.mirror_mode !== due_res.mirror_mode)
          note_mismatch($sformatf(
              "exp tgt=%0d off=%h wr=%b d=%h mir=%0d got tgt=%0d off=%h wr=%b d=%h mir=%0d",
              due_res.target, due_res.phys_offset, due_res.mem_write, due_res.data_out,
              due_res.mirror_mode, seen_res.target, seen_res.phys_offset,
              seen_res.mem_write, seen_res.data_out, seen_res.mirror_mode));
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    prg_count_cfg = PRG_COUNT_RESET;
    chr_count_cfg = CHR_COUNT_RESET;
    ram_fitted = PRG_RAM_RESET;
    bank_8000 = PRG_BANK_RESET;
    bank_a000 = PRG_BANK_RESET;
    swap_on = 1'b0;
    for (int i = 0; i < CHR_SLOTS; i++) chr_map[i] = CHR_BANK_W'(i);
    mirror_now = 2'd0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_access_map();
    test_count_extremes();
    test_random_counts();
    test_back_to_back();
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && due_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* vrc_bank_mapper_core.f */
hw/rtl/vrcm_pkg.sv
hw/rtl/vrcm_chr_store.sv
hw/rtl/vrcm_rem_unit.sv
hw/rtl/vrc_bank_mapper_core.sv
hw/rtl/vrcm_checker.sv
tb/testbench.sv
